### rtl/fztg_pkg.sv
package fztg_pkg;

   localparam int HOLD_SLOTS_DEF  = 8;
   localparam int TARGET_BITS_DEF = 16;
   localparam int REG_BITS        = 16;
   localparam int OP_BITS         = 3;
   localparam int SLOT_BITS       = 3;

   typedef enum logic [OP_BITS-1:0] {
      OP_TICK        = 3'd0,
      OP_INCREASE    = 3'd1,
      OP_DECREASE    = 3'd2,
      OP_SET_FLOOR   = 3'd3,
      OP_TARGET_HOLD = 3'd4,
      OP_FLOOR_HOLD  = 3'd5,
      OP_SET_TARGET  = 3'd6,
      OP_NONE        = 3'd7
   } op_type;

   localparam logic [2:0] CSR_CEILING       = 3'd0;
   localparam logic [2:0] CSR_DEFAULT_FLOOR = 3'd1;
   localparam logic [2:0] CSR_INC_DELAY     = 3'd2;
   localparam logic [2:0] CSR_DEC_INTERVAL  = 3'd3;
   localparam logic [2:0] CSR_REQUEST_BASE  = 3'd4;

endpackage

### rtl/fan_zone_target_governor_top.sv
// Path of an item: it is accepted in idle, executed, and its result registered for the
//   response; floor sets also pass the pull-up state. Hold changes sweep the hold value
//   memory one slot per cycle, then apply the result in the hold state; floor hold changes
//   then also pass the pull-up state. Refused floor changes skip the pull-up and the sweep.
// Throughput: one item at a time; the next beat is taken the cycle after the result is handed off.
// Reset: synchronous, active high; clears target, floor, timers, deltas, hold valid bits.
module fan_zone_target_governor_top #(
   parameter int HOLD_SLOTS  = fztg_pkg::HOLD_SLOTS_DEF,
   parameter int TARGET_BITS = fztg_pkg::TARGET_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fztg_pkg::OP_BITS-1:0]  req_op,
   input  logic [15:0]                   req_amount,
   input  logic [fztg_pkg::SLOT_BITS-1:0] req_slot,
   input  logic                          req_hold_on,
   input  logic                          req_floor_change_ok,
   input  logic                          req_decrease_ok,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [15:0]                   rsp_fan_target,
   output logic [15:0]                   rsp_floor_now,
   output logic                          rsp_zone_active,
   output logic                          rsp_increase_pending,
   input  logic                          csr_write,
   input  logic [2:0]                    csr_index,
   input  logic [15:0]                   csr_data
);

   localparam int TB = TARGET_BITS;
   localparam int AB = (HOLD_SLOTS > 1) ? $clog2(HOLD_SLOTS) : 1;
   localparam int CB = AB + 1;
   localparam int RB = fztg_pkg::REG_BITS;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EXEC  = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_HOLD  = 6'b001000,
      ST_PULL  = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // registers
   logic [TB-1:0] ceiling_ff, dflt_floor_ff, base_ff;
   logic [RB-1:0] inc_delay_ff, dec_int_ff;

   // zone state
   logic [TB-1:0] target_ff, target_in, floor_ff, floor_in;
   logic [TB-1:0] inc_delta_ff, inc_delta_in, dec_delta_ff, dec_delta_in;
   logic [RB-1:0] inc_cnt_ff, inc_cnt_in, dec_cnt_ff, dec_cnt_in;
   logic          inc_run_ff, inc_run_in, active_ff, active_in;
   logic [HOLD_SLOTS-1:0] thv_ff, thv_in, fhv_ff, fhv_in;

   // captured item
   fztg_pkg::op_type op_ff;
   logic [TB-1:0] amount_ff;
   logic [fztg_pkg::SLOT_BITS-1:0] slot_ff;
   logic on_ff, fok_ff, dok_ff;

   // scan
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [TB-1:0] mx_ff, mx_in;
   logic          any_ff, any_in, rd_live_ff, rd_live_in;
   logic [AB-1:0] rd_idx_ff, rd_idx_in;

   logic [TB-1:0] rsp_target_ff, rsp_floor_ff;
   logic          rsp_active_ff, rsp_pend_ff, rsp_valid_ff, rsp_valid_in;

   // memory
   logic          t_we, f_we;
   logic [AB-1:0] wr_addr, rd_addr;
   logic [TB-1:0] wr_data, t_rd, f_rd;

   logic [TB-1:0] amt_in;
   assign amt_in = TB'(req_amount);

   fztg_ram #(.WIDTH(TB), .DEPTH(HOLD_SLOTS)) u_thold (
      .clock(clock), .wr_en(t_we), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(t_rd)
   );
   fztg_ram #(.WIDTH(TB), .DEPTH(HOLD_SLOTS)) u_fhold (
      .clock(clock), .wr_en(f_we), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(f_rd)
   );

   // helpers on current state
   logic [TB-1:0] base_v;
   assign base_v = (base_ff != '0) ? base_ff : target_ff;

   logic          slot_ok;
   logic [AB-1:0] slot_a;
   logic [TB-1:0] fhold_v;
   assign slot_ok = ({{(32-fztg_pkg::SLOT_BITS){1'b0}}, slot_ff} < HOLD_SLOTS);
   assign slot_a  = AB'(slot_ff);
   assign fhold_v = (amount_ff > ceiling_ff) ? ceiling_ff : amount_ff;

   // increase datapath, shared by the increase op and the floor pull-up
   logic [TB-1:0] inc_arg;
   logic [TB:0]   inc_sum;
   logic [TB-1:0] inc_req;
   logic          inc_go;
   always_comb begin
      inc_arg = (op_ff == fztg_pkg::OP_INCREASE) ? amount_ff : floor_ff - target_ff;
      inc_go  = (inc_arg > inc_delta_ff) && (target_ff < ceiling_ff);
      inc_sum = {1'b0, base_v} + {1'b0, inc_arg - inc_delta_ff};
      inc_req = (inc_sum[TB] || inc_sum[TB-1:0] > ceiling_ff) ? ceiling_ff
                                                                 : inc_sum[TB-1:0];
   end

   // tick datapath
   logic [RB-1:0] ic_nx, dc_nx;
   logic          inc_exp, dec_fire, dec_apply;
   logic [TB-1:0] dbase, dec_req;
   always_comb begin
      ic_nx    = (inc_cnt_ff != '1) ? inc_cnt_ff + 1'b1 : inc_cnt_ff;
      inc_exp  = inc_run_ff && (((inc_run_ff ? ic_nx : inc_cnt_ff)) >= inc_delay_ff);
      dc_nx    = (dec_cnt_ff != '1) ? dec_cnt_ff + 1'b1 : dec_cnt_ff;
      dec_fire = (dec_int_ff != '0) && (dc_nx >= dec_int_ff);
      // the fire check sees the increase state after this tick's expiry
      dec_apply = dok_ff && (dec_delta_ff != '0) &&
                  (inc_exp || (!inc_run_ff && inc_delta_ff == '0));
      dbase   = (base_v > ceiling_ff) ? ceiling_ff : base_v;
      dec_req = (dbase < dec_delta_ff || dbase - dec_delta_ff < floor_ff) ? floor_ff
                                                                          : dbase - dec_delta_ff;
   end

   logic [TB-1:0] fl_clamp, dfl;
   assign fl_clamp = (amount_ff > ceiling_ff) ? ceiling_ff : amount_ff;
   assign dfl      = (dflt_floor_ff > ceiling_ff) ? ceiling_ff : dflt_floor_ff;

   logic is_t;
   assign is_t = (op_ff == fztg_pkg::OP_TARGET_HOLD);

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      floor_in     = floor_ff;
      inc_delta_in = inc_delta_ff;
      dec_delta_in = dec_delta_ff;
      inc_cnt_in   = inc_cnt_ff;
      dec_cnt_in   = dec_cnt_ff;
      inc_run_in   = inc_run_ff;
      active_in    = active_ff;
      thv_in       = thv_ff;
      fhv_in       = fhv_ff;
      cnt_in       = cnt_ff;
      mx_in        = mx_ff;
      any_in       = any_ff;
      rd_live_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      t_we         = 1'b0;
      f_we         = 1'b0;
      wr_addr      = slot_a;
      wr_data      = is_t ? amount_ff : fhold_v;
      rd_addr      = cnt_ff[AB-1:0];
      req_ready    = (state_ff == ST_IDLE) && !rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
            case (op_ff)
               fztg_pkg::OP_TICK: begin
                  if (inc_run_ff) begin
                     inc_cnt_in = ic_nx;
                     if (inc_exp) begin
                        inc_run_in   = 1'b0;
                        inc_delta_in = '0;
                     end
                  end
                  if (dec_int_ff != '0) begin
                     dec_cnt_in = dc_nx;
                     if (dec_fire) begin
                        dec_cnt_in   = '0;
                        dec_delta_in = '0;
                        if (dec_apply && active_ff) begin
                           target_in = dec_req;
                        end
                     end
                  end
               end
               fztg_pkg::OP_INCREASE: begin
                  if (inc_go) begin
                     inc_delta_in = inc_arg;
                     if (active_ff) target_in = inc_req;
                     inc_cnt_in = '0;
                     inc_run_in = 1'b1;
                  end
               end
               fztg_pkg::OP_DECREASE: begin
                  if (dec_delta_ff == '0 || amount_ff < dec_delta_ff) begin
                     dec_delta_in = amount_ff;
                  end
               end
               fztg_pkg::OP_SET_FLOOR: begin
                  if (fok_ff) begin
                     floor_in = fl_clamp;
                     state_in = ST_PULL;
                  end
               end
               fztg_pkg::OP_TARGET_HOLD, fztg_pkg::OP_FLOOR_HOLD: begin
                  if (slot_ok) begin
                     if (is_t) begin
                        t_we = on_ff;
                        thv_in[slot_a] = on_ff;
                     end else begin
                        f_we = on_ff;
                        fhv_in[slot_a] = on_ff;
                     end
                  end
                  if (is_t && on_ff) active_in = 1'b0;
                  if (is_t || fok_ff) begin
                     cnt_in   = '0;
                     mx_in    = '0;
                     any_in   = 1'b0;
                     state_in = ST_SCAN;
                  end
               end
               fztg_pkg::OP_SET_TARGET: begin
                  if (active_ff) target_in = amount_ff;
               end
               default: ;
            endcase
         end
         ST_SCAN: begin
            // fold the previous read, issue the next
            if (rd_live_ff) begin
               if ((is_t ? thv_ff[rd_idx_ff] : fhv_ff[rd_idx_ff]) &&
                   (!any_ff || (is_t ? t_rd : f_rd) > mx_ff)) begin
                  mx_in  = is_t ? t_rd : f_rd;
                  any_in = 1'b1;
               end
            end
            if (cnt_ff < CB'(HOLD_SLOTS)) begin
               rd_live_in = 1'b1;
               rd_idx_in  = cnt_ff[AB-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end else if (!rd_live_ff) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            state_in = ST_RESP;
            if (is_t) begin
               if (!any_ff) active_in = 1'b1;
               else         target_in = mx_ff;
            end else begin
               floor_in = any_ff ? mx_ff : dfl;
               state_in = ST_PULL;
            end
         end
         ST_PULL: begin
            state_in = ST_RESP;
            if (target_ff < floor_ff && inc_go) begin
               inc_delta_in = inc_arg;
               if (active_ff) target_in = inc_req;
               inc_cnt_in = '0;
               inc_run_in = 1'b1;
            end
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ceiling_ff    <= TB'(16'hFFFF);
         dflt_floor_ff <= '0;
         inc_delay_ff  <= '0;
         dec_int_ff    <= '0;
         base_ff       <= '0;
         target_ff     <= '0;
         floor_ff      <= '0;
         inc_delta_ff  <= '0;
         dec_delta_ff  <= '0;
         inc_cnt_ff    <= '0;
         dec_cnt_ff    <= '0;
         inc_run_ff    <= 1'b0;
         active_ff     <= 1'b1;
         thv_ff        <= '0;
         fhv_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_live_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         floor_ff     <= floor_in;
         inc_delta_ff <= inc_delta_in;
         dec_delta_ff <= dec_delta_in;
         inc_cnt_ff   <= inc_cnt_in;
         dec_cnt_ff   <= dec_cnt_in;
         inc_run_ff   <= inc_run_in;
         active_ff    <= active_in;
         thv_ff       <= thv_in;
         fhv_ff       <= fhv_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_live_ff   <= rd_live_in;
         if (csr_write) begin
            unique case (csr_index)
               fztg_pkg::CSR_CEILING:       ceiling_ff    <= TB'(csr_data);
               fztg_pkg::CSR_DEFAULT_FLOOR: dflt_floor_ff <= TB'(csr_data);
               fztg_pkg::CSR_INC_DELAY:     inc_delay_ff  <= csr_data;
               fztg_pkg::CSR_DEC_INTERVAL:  dec_int_ff    <= csr_data;
               fztg_pkg::CSR_REQUEST_BASE:  base_ff       <= TB'(csr_data);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      mx_ff     <= mx_in;
      any_ff    <= any_in;
      rd_idx_ff <= rd_idx_in;
      if (req_valid && req_ready) begin
         op_ff     <= fztg_pkg::op_type'(req_op);
         amount_ff <= amt_in;
         slot_ff   <= req_slot;
         on_ff     <= req_hold_on;
         fok_ff    <= req_floor_change_ok;
         dok_ff    <= req_decrease_ok;
      end
      if (state_ff == ST_RESP) begin
         rsp_target_ff <= target_ff;
         rsp_floor_ff  <= floor_ff;
         rsp_active_ff <= active_ff;
         rsp_pend_ff   <= inc_run_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_fan_target       = 16'(rsp_target_ff);
   assign rsp_floor_now        = 16'(rsp_floor_ff);
   assign rsp_zone_active      = rsp_active_ff;
   assign rsp_increase_pending = rsp_pend_ff;

endmodule

### rtl/fztg_ram.sv
module fztg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
